// ----- design/multi_priority_task_queue_assert.svh -----
// Assertion macros for the multi-priority task queue.
// Included by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef MULTI_PRIORITY_TASK_QUEUE_ASSERT_SVH
`define MULTI_PRIORITY_TASK_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MPTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MPTQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mptq_pkg.sv -----
// Shared types and constants for the multi-priority task queue.
// No dependencies; imported by every module of the block except mptq_ram.
package mptq_pkg;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned PRIO_W   = 2;
  localparam int unsigned TOT_W    = 7;
  localparam int unsigned LQ_DEPTH = 4;
  localparam int unsigned LQ_AW    = 2;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } mptq_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } mptq_status_e;

  typedef struct packed {
    logic              task_valid;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] prio;
    mptq_status_e      status;
    logic [TOT_W-1:0]  total;
  } mptq_res_t;

  typedef struct packed {
    logic      valid;
    mptq_res_t res;
  } mptq_push_t;

endpackage

// ----- design/mptq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mptq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- design/mptq_front.sv -----
// Front end: accepts commands, keeps ring pointers and counts, drives the task RAM.
// Depends on mptq_pkg and mptq_ram.
module mptq_front import mptq_pkg::*; #(
  parameter int unsigned NUM_PRIORITIES = 4,
  parameter int unsigned QUEUE_DEPTH    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              prio_en_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [ID_W-1:0]   task_id_i,
  input  logic [PRIO_W-1:0] task_priority_i,
  input  logic [LQ_AW:0]    lq_count_i,
  output mptq_push_t        push_o
);

  localparam int unsigned LW     = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
  localparam int unsigned PW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW     = $clog2(NUM_PRIORITIES * QUEUE_DEPTH + 1);
  localparam int unsigned RDEPTH = NUM_PRIORITIES << PW;
  localparam int unsigned AW     = $clog2(RDEPTH);

  logic [PW-1:0] head_q [NUM_PRIORITIES];
  logic [PW-1:0] head_d [NUM_PRIORITIES];
  logic [PW-1:0] tail_q [NUM_PRIORITIES];
  logic [PW-1:0] tail_d [NUM_PRIORITIES];
  logic [CW-1:0] occ_q  [NUM_PRIORITIES];
  logic [CW-1:0] occ_d  [NUM_PRIORITIES];
  logic [TW-1:0] total_q, total_d;

  logic          s1_valid_q;
  mptq_res_t     s1_res_q;
  mptq_res_t     res_d;

  logic          accept;
  logic [LQ_AW:0] credit;
  logic [LW-1:0] sel, enq_lvl;
  logic          enq_ok, deq_ok;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [ID_W-1:0] ram_rdata;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    n = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  // Room is reserved for the item in stage 1 as well as those already queued.
  assign credit     = lq_count_i + {{LQ_AW{1'b0}}, s1_valid_q};
  assign in_stall_o = credit >= (LQ_AW + 1)'(LQ_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  // With priorities enabled the lowest-numbered non-empty level wins; otherwise level 0.
  always_comb begin
    sel = '0;
    if (prio_en_i) begin
      for (int p = NUM_PRIORITIES - 1; p >= 0; p--) begin
        if (occ_q[p] != '0) begin
          sel = LW'(p);
        end
      end
    end
  end

  assign enq_lvl = LW'(task_priority_i);
  assign enq_ok  = (32'(task_priority_i) < NUM_PRIORITIES) &&
                   (occ_q[enq_lvl] < CW'(QUEUE_DEPTH));
  assign deq_ok  = occ_q[sel] != '0;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    occ_d     = occ_q;
    total_d   = total_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = AW'({enq_lvl, tail_q[enq_lvl]});
    ram_raddr = AW'({sel, head_q[sel]});
    res_d     = '{task_valid: 1'b0, task_id: '0, prio: '0, status: ST_OK, total: '0};
    if (accept) begin
      if (cmd_i == CMD_ENQ) begin
        if (enq_ok) begin
          ram_we           = 1'b1;
          tail_d[enq_lvl]  = ring_next(tail_q[enq_lvl]);
          occ_d[enq_lvl]   = occ_q[enq_lvl] + 1'b1;
          total_d          = total_q + 1'b1;
        end else begin
          res_d.status = ST_FULL;
        end
      end else begin
        if (deq_ok) begin
          ram_re           = 1'b1;
          head_d[sel]      = ring_next(head_q[sel]);
          occ_d[sel]       = occ_q[sel] - 1'b1;
          total_d          = total_q - 1'b1;
          res_d.task_valid = 1'b1;
          res_d.prio       = PRIO_W'(sel);
        end else begin
          res_d.status = ST_EMPTY;
        end
      end
    end
    res_d.total = TOT_W'(total_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PRIORITIES; p++) begin
        head_q[p] <= '0;
        tail_q[p] <= '0;
        occ_q[p]  <= '0;
      end
      total_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      occ_q      <= occ_d;
      total_q    <= total_d;
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res_d;
    end
  end

  mptq_ram #(
    .WIDTH(ID_W),
    .DEPTH(RDEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(task_id_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // RAM data lands in the cycle after the read, alongside the stage 1 record.
  always_comb begin
    push_o.valid        = s1_valid_q;
    push_o.res          = s1_res_q;
    push_o.res.task_id  = s1_res_q.task_valid ? ram_rdata : '0;
  end

endmodule

// ----- design/mptq_link_q.sv -----
// Short result queue between the front end and the output stage.
// Depends on mptq_pkg.
module mptq_link_q import mptq_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mptq_push_t     push_i,
  input  logic           pop_i,
  output mptq_res_t      head_o,
  output logic           nonempty_o,
  output logic [LQ_AW:0] count_o
);

  mptq_res_t        ent_q [LQ_DEPTH];
  logic [LQ_AW-1:0] wr_q, rd_q;
  logic [LQ_AW:0]   cnt_q, cnt_d;

  assign head_o     = ent_q[rd_q];
  assign nonempty_o = cnt_q != '0;
  assign count_o    = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i.valid && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i.valid && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.valid) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      ent_q[wr_q] <= push_i.res;
    end
  end

endmodule

// ----- design/mptq_back.sv -----
// Output stage: moves queued results into the output register toward the consumer.
// Depends on mptq_pkg.
module mptq_back import mptq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mptq_res_t head_i,
  input  logic      nonempty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mptq_res_t out_res_o
);

  logic      out_valid_q;
  mptq_res_t out_res_q;

  assign pop_o       = nonempty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_res_q <= head_i;
    end
  end

endmodule

// ----- design/multi_priority_task_queue.sv -----
// Multi-priority task queue: per-level FIFOs of task ids over one shared task RAM.
// Path: decode and RAM read at the edge that accepts an item, then stage 1 into the link
//   queue, then the link queue into the output register.
// Throughput: one item per cycle; intake stalls only when the 4-entry link queue and
//   the stage 1 register hold four items between them, i.e. when the consumer holds off.
// Reset: pointers, counts and handshakes clear, priorities_enabled = 1; RAM is not cleared.
`include "multi_priority_task_queue_assert.svh"

module multi_priority_task_queue import mptq_pkg::*; #(
  parameter int unsigned NUM_PRIORITIES = 4,
  parameter int unsigned QUEUE_DEPTH    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB-style register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // command channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [ID_W-1:0]   task_id_i,
  input  logic [PRIO_W-1:0] task_priority_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              task_valid_o,
  output logic [ID_W-1:0]   out_task_id_o,
  output logic [PRIO_W-1:0] out_priority_o,
  output logic [1:0]        status_o,
  output logic [TOT_W-1:0]  total_count_o
);

  // Register word index (byte address / 4); only one register exists.
  localparam logic REG_PRIO_EN = 1'b0;

  logic           prio_en_q;
  logic           cfg_wr;
  mptq_push_t     push;
  mptq_res_t      lq_head;
  logic           lq_nonempty;
  logic [LQ_AW:0] lq_count;
  logic           lq_pop;
  mptq_res_t      out_res;

  // ---------------------------------------------------------------------------
  // Register port. Writes land on the access phase; reads are combinational.
  // Writes outside the register list are dropped.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PRIO_EN);
  assign prdata = (paddr[2] == REG_PRIO_EN) ? {31'b0, prio_en_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_en_q <= 1'b1;
    end else if (cfg_wr) begin
      prio_en_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: decodes enqueue/dequeue, updates ring state in the accept cycle
  // and issues the RAM write or read. One item either writes or reads, never
  // both, so there is no same-cycle RAM conflict.
  // ---------------------------------------------------------------------------
  mptq_front #(
    .NUM_PRIORITIES(NUM_PRIORITIES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .prio_en_i      (prio_en_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .task_id_i      (task_id_i),
    .task_priority_i(task_priority_i),
    .lq_count_i     (lq_count),
    .push_o         (push)
  );

  // Link queue decouples the front end from consumer backpressure.
  mptq_link_q u_link (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (lq_pop),
    .head_o    (lq_head),
    .nonempty_o(lq_nonempty),
    .count_o   (lq_count)
  );

  // Output register toward the consumer.
  mptq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (lq_head),
    .nonempty_i (lq_nonempty),
    .pop_o      (lq_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res)
  );

  assign task_valid_o   = out_res.task_valid;
  assign out_task_id_o  = out_res.task_id;
  assign out_priority_o = out_res.prio;
  assign status_o       = out_res.status;
  assign total_count_o  = out_res.total;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `MPTQ_ASSERT_IMP(a_task_means_ok, out_valid_o && task_valid_o, status_o == ST_OK,
    "dequeued task reported with non-ok status")
  `MPTQ_ASSERT_IMP(a_no_task_zero_id, out_valid_o && !task_valid_o,
    out_task_id_o == '0 && out_priority_o == '0, "empty result carries task fields")
  `MPTQ_ASSERT_IMP(a_link_bound, 1'b1, lq_count <= LQ_DEPTH,
    "link queue overfilled")
  `MPTQ_ASSERT_NXT(a_cfg_write, cfg_wr, prio_en_q == $past(pwdata[0]),
    "priorities_enabled write lost")

endmodule
